FILE: src/tac_pkg.sv
// Shared types and constants for the tile average colour block.
`default_nettype none
package tac_pkg;

	// Field widths
	localparam int PIX_W   = 8;
	localparam int SIDE_W  = 9;
	localparam int SUM_W   = 24;
	localparam int CNT_W   = 17;
	localparam int CHANS   = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIDE_W;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 1'd1;

	// Default upper bound on a tile side
	localparam int MAX_TILE_SIDE_DEF = 256;

	// Controller to datapath
	typedef struct packed {
		logic accept;	// pixel request taken this cycle
		logic load;		// tile finished: hand sums to the divider
		logic step;		// one quotient bit per channel
	} tac_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_pixel;	// the pixel on offer completes the tile
	} tac_status_t;

endpackage
`default_nettype wire

FILE: src/tac_ctrl.sv
// Controller: request handshakes and sequencing of the shift-subtract divider.
`default_nettype none
module tac_ctrl
	import tac_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire tac_status_t status,
	output tac_cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	localparam int QBITS = PIX_W;
	localparam int STEP_W = $clog2(QBITS);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	// Pixels flow freely; only the closing pixel of a tile waits until the divider is done and its result taken
	assign in_ready  = !status.last_pixel || (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);

	assign cmd.accept = accept;
	assign cmd.load   = accept && status.last_pixel;
	assign cmd.step   = (state_q == ST_DIV);

	// State register and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
						step_q  <= STEP_W'(QBITS - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/tac_datapath.sv
// Datapath: size registers, channel accumulators and the three-lane divider.
`default_nettype none
module tac_datapath
	import tac_pkg::*;
#(
	parameter int MAX_TILE_SIDE = MAX_TILE_SIDE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [PIX_W-1:0]      pixel_red,
	input  wire logic [PIX_W-1:0]      pixel_green,
	input  wire logic [PIX_W-1:0]      pixel_blue,
	input  wire tac_cmd_t              cmd,
	output tac_status_t                status,
	output logic [PIX_W-1:0]           avg_red,
	output logic [PIX_W-1:0]           avg_green,
	output logic [PIX_W-1:0]           avg_blue
);

	localparam int SIDE_CAP_I = (MAX_TILE_SIDE < 256) ? MAX_TILE_SIDE : 256;
	localparam logic [SIDE_W-1:0] SIDE_CAP = SIDE_W'(SIDE_CAP_I);
	localparam int SHIFT = PIX_W - 1;

	logic [SIDE_W-1:0] width_q, height_q;
	logic [SIDE_W-1:0] width_eff, height_eff;
	logic [2*SIDE_W-1:0] target;
	logic [CNT_W:0]      count_inc;

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q   [CHANS];
	logic [SUM_W-1:0] sum_new [CHANS];
	logic [PIX_W-1:0] pix     [CHANS];

	logic [SUM_W-1:0] rem_q   [CHANS];
	logic [SUM_W-1:0] dvs_q;
	logic [PIX_W-1:0] quo_q   [CHANS];

	// Clamp a side register to 1..cap
	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] r);
		logic [SIDE_W-1:0] s;
		s = r;
		if (s == '0) s = SIDE_W'(1);
		if (s > SIDE_CAP) s = SIDE_CAP;
		return s;
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(1);
			height_q <= SIDE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TILE_WIDTH:  width_q  <= cfg_data;
				REG_TILE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Tile size and end-of-tile detect
	assign width_eff  = eff_side(width_q);
	assign height_eff = eff_side(height_q);
	assign target     = width_eff * height_eff;
	assign count_inc  = {1'b0, count_q} + 1'b1;
	assign status.last_pixel = (count_inc >= target);

	assign pix[0] = pixel_red;
	assign pix[1] = pixel_green;
	assign pix[2] = pixel_blue;

	always_comb begin
		for (int c = 0; c < CHANS; c++) begin
			sum_new[c] = sum_q[c] + SUM_W'(pix[c]);
		end
	end

	// Accumulators, cleared as a finished tile leaves for the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int c = 0; c < CHANS; c++) sum_q[c] <= '0;
		end else if (cmd.accept) begin
			if (cmd.load) begin
				count_q <= '0;
				for (int c = 0; c < CHANS; c++) sum_q[c] <= '0;
			end else begin
				count_q <= count_inc[CNT_W-1:0];
				for (int c = 0; c < CHANS; c++) sum_q[c] <= sum_new[c];
			end
		end
	end

	// Restoring divider, MSB first; the mean never exceeds 255 so 8 bits suffice
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvs_q <= SUM_W'(count_inc[CNT_W-1:0]) << SHIFT;
			for (int c = 0; c < CHANS; c++) rem_q[c] <= sum_new[c];
		end else if (cmd.step) begin
			dvs_q <= dvs_q >> 1;
			for (int c = 0; c < CHANS; c++) begin
				if (rem_q[c] >= dvs_q) begin
					rem_q[c] <= rem_q[c] - dvs_q;
					quo_q[c] <= {quo_q[c][PIX_W-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][PIX_W-2:0], 1'b0};
				end
			end
		end
	end

	assign avg_red   = quo_q[0];
	assign avg_green = quo_q[1];
	assign avg_blue  = quo_q[2];

endmodule
`default_nettype wire

FILE: src/tile_average_color.sv
// Tile average colour: a pixel per cycle in, the mean RGB of each tile out.
// Throughput: one pixel request per cycle; the closing pixel of a tile waits
// while the previous tile is still dividing or its result is not yet taken.
// Result: when the closing pixel is accepted the sums load into the 8-step
// shift-subtract divider, run on all three channels at once; out_valid rises after its last step.
// Reset: sums and count cleared, both tile sides set to 1, controller idle.
`default_nettype none
module tile_average_color
	import tac_pkg::*;
#(
	parameter int MAX_TILE_SIDE = MAX_TILE_SIDE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [PIX_W-1:0]      pixel_red,
	input  wire logic [PIX_W-1:0]      pixel_green,
	input  wire logic [PIX_W-1:0]      pixel_blue,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PIX_W-1:0]           avg_red,
	output logic [PIX_W-1:0]           avg_green,
	output logic [PIX_W-1:0]           avg_blue
);

	tac_cmd_t    cmd;
	tac_status_t status;

	tac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tac_datapath #(
		.MAX_TILE_SIDE (MAX_TILE_SIDE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.cmd         (cmd),
		.status      (status),
		.avg_red     (avg_red),
		.avg_green   (avg_green),
		.avg_blue    (avg_blue)
	);

endmodule
`default_nettype wire
